>>> hdl/hilbert_index_point_convert_assert.svh
// assertion macros used by the checker file
`ifndef HILBERT_INDEX_POINT_CONVERT_ASSERT_SVH
`define HILBERT_INDEX_POINT_CONVERT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define HIPC_ASSERT_NOW(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hipc assertion failed");

// consequent holds in the cycle after the antecedent
`define HIPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hipc assertion failed");

`endif

>>> hdl/hipc_pkg.sv
// shared types, constants and helpers of the hilbert point converter
package hipc_pkg;

    localparam int MAX_DIMS  = 4;
    localparam int MAX_BITS  = 16;
    localparam int DIST_W    = 64;
    localparam int COORD_W   = 16;
    localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int LVL_W     = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int NUM_CELLS = MAX_BITS - 1;
    localparam int PADDR_W   = 3;

    localparam logic [4:0] BITS_RESET = 5'd16;
    localparam logic [2:0] DIMS_RESET = 3'd2;

    typedef enum logic {
        OP_TO_DIST  = 1'b0,
        OP_TO_POINT = 1'b1
    } op_t;

    typedef enum logic {
        REG_BITS_PER_DIM = 1'b0,
        REG_NUM_DIMS     = 1'b1
    } reg_idx_t;

    typedef logic [MAX_BITS-1:0] coord_t;
    typedef logic [MAX_DIMS-1:0][MAX_BITS-1:0] point_t;

    typedef struct packed {
        logic [4:0] p;
        logic [2:0] n;
    } cfg_t;

    typedef struct packed {
        op_t    op;
        point_t x;
    } item_t;

    function automatic coord_t low_mask(logic [4:0] p);
        coord_t m;
        m = '0;
        for (int b = 0; b < MAX_BITS; b++)
        begin
            m[b] = (b < int'(p));
        end
        return m;
    endfunction

endpackage

>>> hdl/hipc_prep.sv
// input stage: masking, plus de-interleave and gray decode of a distance, registered
module hipc_prep
    import hipc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  op_t               opcode,
    input  logic [DIST_W-1:0] dist_in,
    input  point_t            coord_in,
    output logic              dn_valid,
    input  logic              dn_ready,
    output item_t             dn_item
);

    logic   vld_reg;
    item_t  item_reg;
    item_t  item_next;
    point_t cand [MAX_DIMS];
    point_t dec;
    point_t enc;
    coord_t cmask;
    coord_t t;
    logic [DIM_W-1:0] nidx;

    always_comb
    begin
        cmask = low_mask(cfg.p);
        nidx  = DIM_W'(cfg.n - 3'd1);
        for (int nn = 1; nn <= MAX_DIMS; nn++)
        begin
            cand[nn-1] = '0;
            for (int i = 0; i < nn; i++)
            begin
                for (int b = 0; b < MAX_BITS; b++)
                begin
                    if (b * nn + nn - 1 - i < DIST_W)
                    begin
                        cand[nn-1][i][b] = dist_in[b * nn + nn - 1 - i];
                    end
                end
            end
        end
        dec = cand[nidx];
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            dec[i] = dec[i] & cmask;
            enc[i] = (i < int'(cfg.n)) ? (coord_in[i] & cmask) : '0;
        end
        // gray decode of the transposed point
        t = dec[nidx] >> 1;
        for (int i = MAX_DIMS - 1; i > 0; i--)
        begin
            if (i < int'(cfg.n))
            begin
                dec[i] = dec[i] ^ dec[i-1];
            end
        end
        dec[0] = dec[0] ^ t;
        item_next.op = opcode;
        item_next.x  = (opcode == OP_TO_POINT) ? dec : enc;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hdl/hipc_cell.sv
// one bit level of the excess transform, registered
module hipc_cell
    import hipc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic [LVL_W-1:0] enc_lvl,
    input  logic [LVL_W-1:0] dec_lvl,
    input  logic             up_valid,
    output logic             up_ready,
    input  item_t            up_item,
    output logic             dn_valid,
    input  logic             dn_ready,
    output item_t            dn_item
);

    logic             vld_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [LVL_W-1:0] lvl;
    logic             active;
    coord_t           q;
    coord_t           low;
    coord_t           t;
    logic [DIM_W-1:0] idx;
    point_t           x;

    always_comb
    begin
        lvl    = (up_item.op == OP_TO_POINT) ? dec_lvl : enc_lvl;
        active = (5'(lvl) < cfg.p);
        q      = coord_t'(1) << lvl;
        low    = q - coord_t'(1);
        x      = up_item.x;
        idx    = '0;
        t      = '0;
        // encode walks the dimensions upward, decode downward
        for (int j = 0; j < MAX_DIMS; j++)
        begin
            if (active && (j < int'(cfg.n)))
            begin
                idx = (up_item.op == OP_TO_POINT) ? DIM_W'(cfg.n - 3'd1 - 3'(j))
                                                  : DIM_W'(j);
                if ((x[idx] & q) != '0)
                begin
                    x[0] = x[0] ^ low;
                end
                else
                begin
                    t      = (x[0] ^ x[idx]) & low;
                    x[0]   = x[0] ^ t;
                    x[idx] = x[idx] ^ t;
                end
            end
        end
        item_next.op = up_item.op;
        item_next.x  = x;
    end

    assign up_ready = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hdl/hipc_post.sv
// output stage: gray encode and interleave for a distance result, result register
module hipc_post
    import hipc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              up_valid,
    output logic              up_ready,
    input  item_t             up_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIST_W-1:0] dist_out,
    output point_t            coord_out
);

    logic              vld_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    point_t            coord_reg;
    point_t            coord_next;
    logic [DIST_W-1:0] cand [MAX_DIMS];
    point_t            x;
    coord_t            t;
    logic [DIM_W-1:0]  nidx;

    always_comb
    begin
        nidx = DIM_W'(cfg.n - 3'd1);
        x    = up_item.x;
        for (int i = 1; i < MAX_DIMS; i++)
        begin
            if (i < int'(cfg.n))
            begin
                x[i] = x[i] ^ x[i-1];
            end
        end
        // parity of the higher bits of the last dimension
        for (int j = 0; j < MAX_BITS; j++)
        begin
            t[j] = ^(x[nidx] >> (j + 1));
        end
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (i < int'(cfg.n))
            begin
                x[i] = x[i] ^ t;
            end
        end
        for (int nn = 1; nn <= MAX_DIMS; nn++)
        begin
            cand[nn-1] = '0;
            for (int i = 0; i < nn; i++)
            begin
                for (int b = 0; b < MAX_BITS; b++)
                begin
                    if (b * nn + nn - 1 - i < DIST_W)
                    begin
                        cand[nn-1][b * nn + nn - 1 - i] = x[i][b];
                    end
                end
            end
        end
        if (up_item.op == OP_TO_POINT)
        begin
            dist_next  = '0;
            coord_next = up_item.x;
        end
        else
        begin
            dist_next  = cand[nidx];
            coord_next = '0;
        end
    end

    assign up_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign dist_out  = dist_reg;
    assign coord_out = coord_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            dist_reg  <= dist_next;
            coord_reg <= coord_next;
        end
    end

endmodule

>>> hdl/hilbert_index_point_convert.sv
// top level of the hilbert point and distance converter
//
// input channel: in_valid/in_ready with opcode, dist_in and coord_in0..3;
// opcode 0 turns a point into its hilbert distance, opcode 1 the reverse
// output channel: out_valid/out_ready with dist_out and coord_out0..3;
// fields not produced by the item's opcode read as zero
// apb port: bits_per_dim at 0x0, num_dims at 0x4, write only while idle
// datapath: 17 registers from input accept to out_valid (input
// stage, one cell per bit level above the lowest, output register)
// throughput: one item per cycle while out_ready holds; every stage holds an item and its valid
// bit, so the chain keeps taking items while earlier ones move through it
// stall: a stage holds its item while the stage after it is full and stuck;
// in_ready drops only once every stage is occupied
// reset: all stages empty, bits_per_dim = 16, num_dims = 2
module hilbert_index_point_convert
    import hipc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [DIST_W-1:0]  dist_in,
    input  logic [COORD_W-1:0] coord_in0,
    input  logic [COORD_W-1:0] coord_in1,
    input  logic [COORD_W-1:0] coord_in2,
    input  logic [COORD_W-1:0] coord_in3,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIST_W-1:0]  dist_out,
    output logic [COORD_W-1:0] coord_out0,
    output logic [COORD_W-1:0] coord_out1,
    output logic [COORD_W-1:0] coord_out2,
    output logic [COORD_W-1:0] coord_out3,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [4:0] bits_per_dim_reg;
    logic [2:0] num_dims_reg;
    cfg_t       cfg;
    reg_idx_t   reg_sel;
    logic       wr_en;
    point_t     coord_pt;
    point_t     coord_res;

    logic  stg_valid [NUM_CELLS+1];
    logic  stg_ready [NUM_CELLS+1];
    item_t stg_item  [NUM_CELLS+1];

    // apb registers
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_per_dim_reg <= BITS_RESET;
            num_dims_reg     <= DIMS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BITS_PER_DIM: bits_per_dim_reg <= pwdata[4:0];
                REG_NUM_DIMS:     num_dims_reg     <= pwdata[2:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BITS_PER_DIM: prdata = {27'd0, bits_per_dim_reg};
            REG_NUM_DIMS:     prdata = {29'd0, num_dims_reg};
            default:          prdata = '0;
        endcase
    end

    // clamp to the supported range
    always_comb
    begin
        if (bits_per_dim_reg == 5'd0)
            cfg.p = 5'd1;
        else if (int'(bits_per_dim_reg) > MAX_BITS)
            cfg.p = 5'(MAX_BITS);
        else
            cfg.p = bits_per_dim_reg;
        if (num_dims_reg == 3'd0)
            cfg.n = 3'd1;
        else if (int'(num_dims_reg) > MAX_DIMS)
            cfg.n = 3'(MAX_DIMS);
        else
            cfg.n = num_dims_reg;
    end

    always_comb
    begin
        coord_pt    = '0;
        coord_pt[0] = MAX_BITS'(coord_in0);
        if (MAX_DIMS > 1) coord_pt[1 % MAX_DIMS] = MAX_BITS'(coord_in1);
        if (MAX_DIMS > 2) coord_pt[2 % MAX_DIMS] = MAX_BITS'(coord_in2);
        if (MAX_DIMS > 3) coord_pt[3 % MAX_DIMS] = MAX_BITS'(coord_in3);
    end

    hipc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .opcode   (op_t'(opcode)),
        .dist_in  (dist_in),
        .coord_in (coord_pt),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_item  (stg_item[0])
    );

    for (genvar s = 0; s < NUM_CELLS; s++)
    begin : g_cell
        hipc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cfg      (cfg),
            .enc_lvl  (LVL_W'(MAX_BITS - 1 - s)),
            .dec_lvl  (LVL_W'(s + 1)),
            .up_valid (stg_valid[s]),
            .up_ready (stg_ready[s]),
            .up_item  (stg_item[s]),
            .dn_valid (stg_valid[s+1]),
            .dn_ready (stg_ready[s+1]),
            .dn_item  (stg_item[s+1])
        );
    end

    hipc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (stg_valid[NUM_CELLS]),
        .up_ready  (stg_ready[NUM_CELLS]),
        .up_item   (stg_item[NUM_CELLS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dist_out  (dist_out),
        .coord_out (coord_res)
    );

    assign coord_out0 = COORD_W'(coord_res[0]);
    assign coord_out1 = (MAX_DIMS > 1) ? COORD_W'(coord_res[1 % MAX_DIMS]) : '0;
    assign coord_out2 = (MAX_DIMS > 2) ? COORD_W'(coord_res[2 % MAX_DIMS]) : '0;
    assign coord_out3 = (MAX_DIMS > 3) ? COORD_W'(coord_res[3 % MAX_DIMS]) : '0;

endmodule

>>> hdl/hipc_checker.sv
// port level checks of the hilbert point converter and their binding
`include "hilbert_index_point_convert_assert.svh"

module hipc_checker
    import hipc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DIST_W-1:0]  dist_out,
    input logic [COORD_W-1:0] coord_out0,
    input logic [COORD_W-1:0] coord_out1,
    input logic [COORD_W-1:0] coord_out2,
    input logic [COORD_W-1:0] coord_out3,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata
);

    // a stalled item holds its distance and coordinates 0 and 3
    `HIPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(dist_out) && $stable(coord_out0) && $stable(coord_out3))

    // a free output register means the chain can take an item
    `HIPC_ASSERT_NOW(a_ready_free, !out_valid || out_ready |-> in_ready)

    // an item carries either a distance or a point, never both
    `HIPC_ASSERT_NOW(a_one_result, !out_valid || dist_out == '0 ||
        (coord_out0 == '0 && coord_out1 == '0 && coord_out2 == '0 && coord_out3 == '0))

    // order register reads back what was written
    `HIPC_ASSERT_NEXT(a_cfg_readback,
        psel && penable && pwrite && reg_idx_t'(paddr[2]) == REG_BITS_PER_DIM,
        reg_idx_t'(paddr[2]) != REG_BITS_PER_DIM || prdata[4:0] == $past(pwdata[4:0]))

endmodule

bind hilbert_index_point_convert hipc_checker u_hipc_checker (.*);
